// ----- rtl/vfm_pkg.sv -----
// Shared types, constants and lookup functions for the voxel face mesher.
// Holds the input, result and queued job structs, face geometry tables and the shade table.
// Depends on nothing; vfm_front, vfm_back and the top level import it.
package vfm_pkg;

  localparam logic [15:0] CAP_RESET = 16'd65532;
  localparam int unsigned NumFaces = 6;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  typedef struct packed {
    logic        start_of_chunk;
    logic [3:0]  voxel_x;
    logic [3:0]  voxel_y;
    logic [3:0]  voxel_z;
    logic [7:0]  block_kind;
    logic        self_liquid;
    logic [5:0]  side_opaque;
    logic [5:0]  side_liquid;
    logic [26:0] occluder_mask;
    logic [23:0] face_light;
  } vfm_in_t;

  typedef struct packed {
    logic [4:0]  corner_x;
    logic [4:0]  corner_y;
    logic [4:0]  corner_z;
    logic [2:0]  face_dir;
    logic [1:0]  corner_no;
    logic [15:0] shade;
    logic [7:0]  block_out;
    logic [15:0] vertex_index;
    logic        last;
  } vfm_out_t;

  typedef struct packed {
    logic [3:0]  voxel_x;
    logic [3:0]  voxel_y;
    logic [3:0]  voxel_z;
    logic [7:0]  block_kind;
    logic [5:0]  face_mask;
    logic [26:0] occluder_mask;
    logic [23:0] face_light;
    logic [15:0] base_index;
  } vfm_job_t;

  // Corner offset {dx, dy, dz} of each corner of each face.
  function automatic logic [2:0] corner_offset(input logic [2:0] face, input logic [1:0] corner);
    logic [2:0] ofs;
    ofs = 3'b000;
    case (face)
      FACE_PX: begin
        case (corner)
          2'd0: ofs = 3'b100;
          2'd1: ofs = 3'b110;
          2'd2: ofs = 3'b111;
          default: ofs = 3'b101;
        endcase
      end
      FACE_NX: begin
        case (corner)
          2'd0: ofs = 3'b001;
          2'd1: ofs = 3'b011;
          2'd2: ofs = 3'b010;
          default: ofs = 3'b000;
        endcase
      end
      FACE_PY: begin
        case (corner)
          2'd0: ofs = 3'b011;
          2'd1: ofs = 3'b111;
          2'd2: ofs = 3'b110;
          default: ofs = 3'b010;
        endcase
      end
      FACE_NY: begin
        case (corner)
          2'd0: ofs = 3'b000;
          2'd1: ofs = 3'b100;
          2'd2: ofs = 3'b101;
          default: ofs = 3'b001;
        endcase
      end
      FACE_PZ: begin
        case (corner)
          2'd0: ofs = 3'b101;
          2'd1: ofs = 3'b111;
          2'd2: ofs = 3'b011;
          default: ofs = 3'b001;
        endcase
      end
      default: begin
        case (corner)
          2'd0: ofs = 3'b000;
          2'd1: ofs = 3'b010;
          2'd2: ofs = 3'b110;
          default: ofs = 3'b100;
        endcase
      end
    endcase
    return ofs;
  endfunction

  // Occluder mask bit numbers {side1, side2, diagonal} for each corner of each face.
  function automatic logic [14:0] occ_taps(input logic [2:0] face, input logic [1:0] corner);
    logic [14:0] taps;
    taps = '0;
    case (face)
      FACE_PX: begin
        case (corner)
          2'd0: taps = {5'd5, 5'd11, 5'd2};
          2'd1: taps = {5'd5, 5'd17, 5'd8};
          2'd2: taps = {5'd23, 5'd17, 5'd26};
          default: taps = {5'd23, 5'd11, 5'd20};
        endcase
      end
      FACE_NX: begin
        case (corner)
          2'd0: taps = {5'd21, 5'd9, 5'd18};
          2'd1: taps = {5'd21, 5'd15, 5'd24};
          2'd2: taps = {5'd3, 5'd15, 5'd6};
          default: taps = {5'd3, 5'd9, 5'd0};
        endcase
      end
      FACE_PY: begin
        case (corner)
          2'd0: taps = {5'd15, 5'd25, 5'd24};
          2'd1: taps = {5'd17, 5'd25, 5'd26};
          2'd2: taps = {5'd17, 5'd7, 5'd8};
          default: taps = {5'd15, 5'd7, 5'd6};
        endcase
      end
      FACE_NY: begin
        case (corner)
          2'd0: taps = {5'd9, 5'd1, 5'd0};
          2'd1: taps = {5'd11, 5'd1, 5'd2};
          2'd2: taps = {5'd11, 5'd19, 5'd20};
          default: taps = {5'd9, 5'd19, 5'd18};
        endcase
      end
      FACE_PZ: begin
        case (corner)
          2'd0: taps = {5'd23, 5'd19, 5'd20};
          2'd1: taps = {5'd23, 5'd25, 5'd26};
          2'd2: taps = {5'd21, 5'd25, 5'd24};
          default: taps = {5'd21, 5'd19, 5'd18};
        endcase
      end
      default: begin
        case (corner)
          2'd0: taps = {5'd3, 5'd1, 5'd0};
          2'd1: taps = {5'd3, 5'd7, 5'd6};
          2'd2: taps = {5'd5, 5'd7, 5'd8};
          default: taps = {5'd5, 5'd1, 5'd2};
        endcase
      end
    endcase
    return taps;
  endfunction

  // Shade in Q1.15 for each light level and occlusion level, entry index {light, ao}.
  function automatic logic [1023:0] build_shade_lut();
    logic [1023:0] lut;
    int unsigned num;
    int unsigned val;
    lut = '0;
    for (int unsigned l = 0; l < 16; l++) begin
      for (int unsigned a = 0; a < 4; a++) begin
        num = (17 * l + 45) * (11 + 3 * a);
        val = (num * 32768 + 3000) / 6000;
        lut[(l * 4 + a) * 16 +: 16] = val[15:0];
      end
    end
    return lut;
  endfunction

  localparam logic [1023:0] SHADE_LUT = build_shade_lut();

endpackage

// ----- rtl/vfm_queue.sv -----
// Register-based FIFO that carries classified voxel jobs from the front to the back.
// Generic in width and depth; depends on no package.
module vfm_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/vfm_front.sv -----
// Front end of the mesher: takes voxels, culls faces, applies the vertex cap per chunk.
// Holds the cap register, vertex count and stop flag; emits jobs with a face mask.
// Depends on vfm_pkg.
module vfm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vfm_pkg::vfm_in_t  in_data_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output vfm_pkg::vfm_job_t job_o
);
  import vfm_pkg::*;

  logic [15:0] cap_q;
  logic [15:0] count_q, count_d;
  logic        stopped_q, stopped_d;
  logic [15:0] cnt_base;
  logic        stop_base;
  logic [5:0]  uncull;
  logic [16:0] room;
  logic [2:0]  allowed;
  logic [5:0]  emit;
  logic [2:0]  n_emit;
  logic [2:0]  n_low;
  logic        active;
  logic        stop_now;
  logic        accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  assign cnt_base  = in_data_i.start_of_chunk ? '0 : count_q;
  assign stop_base = in_data_i.start_of_chunk ? 1'b0 : stopped_q;
  assign active    = (in_data_i.block_kind != '0) && !stop_base;
  assign uncull    = ~in_data_i.side_opaque &
                     ~({6{in_data_i.self_liquid}} & in_data_i.side_liquid);
  assign room      = {1'b0, cap_q} - {1'b0, cnt_base};

  always_comb begin
    if (room[16]) begin
      allowed = 3'd0;
    end else if (room[15:2] >= 14'd6) begin
      allowed = 3'd6;
    end else begin
      allowed = room[4:2];
    end
  end

  // The first faces that pass culling are kept, up to the room left under the cap.
  always_comb begin
    emit   = '0;
    n_emit = '0;
    n_low  = '0;
    for (int f = 0; f < NumFaces; f++) begin
      if (uncull[f] && (n_emit < allowed)) begin
        emit[f] = 1'b1;
        n_emit  = n_emit + 1'b1;
      end
    end
    for (int f = 0; f < NumFaces - 1; f++) begin
      n_low = n_low + {2'b00, uncull[f]};
    end
  end

  // The cap check fails at some face exactly when the faces before the last one fill the room.
  assign stop_now = (n_low >= allowed);

  always_comb begin
    count_d   = cnt_base;
    stopped_d = stop_base;
    if (active) begin
      count_d   = cnt_base + {11'b0, n_emit, 2'b00};
      stopped_d = stop_now;
    end
  end

  assign job_valid_o         = in_valid_i && active && (emit != '0);
  assign job_o.voxel_x       = in_data_i.voxel_x;
  assign job_o.voxel_y       = in_data_i.voxel_y;
  assign job_o.voxel_z       = in_data_i.voxel_z;
  assign job_o.block_kind    = in_data_i.block_kind;
  assign job_o.face_mask     = emit;
  assign job_o.occluder_mask = in_data_i.occluder_mask;
  assign job_o.face_light    = in_data_i.face_light;
  assign job_o.base_index    = cnt_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      count_q   <= '0;
      stopped_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        count_q   <= count_d;
        stopped_q <= stopped_d;
      end
    end
  end

endmodule

// ----- rtl/vfm_back.sv -----
// Back end: walks the head job's face mask, one vertex per cycle unless stalled.
// Computes corner position, ambient occlusion and shade into an output register.
// Depends on vfm_pkg.
module vfm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  vfm_pkg::vfm_job_t job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vfm_pkg::vfm_out_t out_data_o
);
  import vfm_pkg::*;

  logic [5:0]  done_q, done_d;
  logic [1:0]  corner_q, corner_d;
  logic [4:0]  offset_q, offset_d;
  logic        out_valid_q;
  vfm_out_t    out_q;
  vfm_out_t    vert;
  logic [5:0]  pend;
  logic [2:0]  face;
  logic [5:0]  face_bit;
  logic        face_done;
  logic        last_v;
  logic        adv;
  logic [2:0]  ofs;
  logic [14:0] taps;
  logic        s1, s2, dg;
  logic [1:0]  ao;
  logic [3:0]  light;

  assign pend = job_i.face_mask & ~done_q;

  always_comb begin
    face = FACE_NZ;
    for (int f = NumFaces - 1; f >= 0; f--) begin
      if (pend[f]) begin
        face = 3'(f);
      end
    end
  end

  assign face_bit  = 6'b000001 << face;
  assign face_done = (corner_q == 2'd3);
  assign last_v    = face_done && ((pend & ~face_bit) == '0);
  assign adv       = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_ready_o = adv && last_v;

  assign ofs   = corner_offset(face, corner_q);
  assign taps  = occ_taps(face, corner_q);
  assign s1    = job_i.occluder_mask[taps[14:10]];
  assign s2    = job_i.occluder_mask[taps[9:5]];
  assign dg    = job_i.occluder_mask[taps[4:0]];
  assign ao    = (s1 && s2) ? 2'd0 : 2'd3 - ({1'b0, s1} + {1'b0, s2} + {1'b0, dg});
  assign light = job_i.face_light[{face, 2'b00} +: 4];

  always_comb begin
    vert.corner_x     = {1'b0, job_i.voxel_x} + {4'b0, ofs[2]};
    vert.corner_y     = {1'b0, job_i.voxel_y} + {4'b0, ofs[1]};
    vert.corner_z     = {1'b0, job_i.voxel_z} + {4'b0, ofs[0]};
    vert.face_dir     = face;
    vert.corner_no    = corner_q;
    vert.shade        = SHADE_LUT[{light, ao, 4'b0000} +: 16];
    vert.block_out    = job_i.block_kind;
    vert.vertex_index = job_i.base_index + {11'b0, offset_q};
    vert.last         = last_v;
  end

  always_comb begin
    done_d   = done_q;
    corner_d = corner_q;
    offset_d = offset_q;
    if (adv) begin
      corner_d = corner_q + 1'b1;
      offset_d = offset_q + 1'b1;
      if (face_done) begin
        done_d = done_q | face_bit;
      end
      if (last_v) begin
        done_d   = '0;
        corner_d = '0;
        offset_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      corner_q    <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q   <= done_d;
      corner_q <= corner_d;
      offset_q <= offset_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= vert;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A queued job always has a face left to emit.
  a_pending_face : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> (pend != '0))
    else $error("Head job has no face left to emit.");

  // The running vertex offset stays aligned with the corner counter.
  a_offset_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_q[1:0] == corner_q)
    else $error("Vertex offset out of step with corner number.");

  // Finishing a job leaves a last-marked vertex in the output register.
  a_last_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_v) |=> (out_valid_q && out_q.last))
    else $error("Final vertex of a voxel not marked last.");

endmodule

// ----- rtl/voxel_face_mesher_with_ao.sv -----
// Voxel face mesher with ambient occlusion: one voxel in, a four-vertex quad per visible face out.
// First vertex passes the job queue and output register; then one vertex per cycle unless stalled.
// A voxel with n emitted faces yields 4*n vertices from the vertex unit; voxels
// with no faces push no job, and inputs are taken each cycle while the job queue has room.
// Reset: vertex count and stop flag cleared, cap set to 65532, queue and output register empty.
// Depends on vfm_pkg, vfm_front, vfm_queue and vfm_back.
module voxel_face_mesher_with_ao #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vfm_pkg::vfm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vfm_pkg::vfm_out_t out_data_o
);
  import vfm_pkg::*;

  logic     fj_valid, fj_ready;
  vfm_job_t fj_data;
  logic     bj_valid, bj_ready;
  vfm_job_t bj_data;

  vfm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj_data)
  );

  vfm_queue #(
    .WIDTH ($bits(vfm_job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj_data),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_data_o   (bj_data)
  );

  vfm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_i       (bj_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
